### sv/bfsip_pkg.sv
// shared types and constants for the siphash bloom filter
package bfsip_pkg;

    localparam logic [63:0] KEY_MUL0 = 64'h517cc1b727220a95;
    localparam logic [63:0] KEY_MUL1 = 64'h6c62272e07bb0142;
    localparam logic [63:0] SIP_IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_IV3 = 64'h7465646279746573;
    localparam logic [7:0]  MSG_LEN = 8'd36;

    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_SEED  = 2'd2;

    localparam logic [20:0] RESET_SIZE  = 21'd1048576;
    localparam logic [4:0]  RESET_COUNT = 5'd7;
    localparam logic [4:0]  MAX_HASHES  = 5'd30;
    localparam logic [20:0] MIN_SIZE    = 21'd8;

    typedef struct packed {
        logic        mode;
        logic [63:0] txid_word0;
        logic [63:0] txid_word1;
        logic [63:0] txid_word2;
        logic [63:0] txid_word3;
        logic [31:0] out_index;
    } bfsip_in_t;

    typedef struct packed {
        logic was_query;
        logic may_contain;
    } bfsip_out_t;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_state_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    // one siphash round
    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t t;
        t = s;
        t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 = t.v1 ^ t.v0;
        t.v0 = rotl(t.v0, 32);
        t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 = t.v3 ^ t.v2;
        t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 = t.v3 ^ t.v0;
        t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 = t.v1 ^ t.v2;
        t.v2 = rotl(t.v2, 32);
        sip_round = t;
    endfunction

endpackage

### sv/bfsip_ram.sv
// generic single port ram with registered read
module bfsip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### sv/bfsip_hash.sv
// iterative siphash-2-4 over a 36 byte outpoint, one round per cycle
module bfsip_hash
    import bfsip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] k0,
    input  logic [63:0] k1,
    input  logic [63:0] w0,
    input  logic [63:0] w1,
    input  logic [63:0] w2,
    input  logic [63:0] w3,
    input  logic [31:0] idx,
    output logic        done,
    output logic [63:0] hash
);
    // step counter: 5 words x 2 rounds, then 4 final rounds
    logic [3:0]  step_reg, step_next;
    logic        run_reg, run_next;
    sip_state_t  st_reg, st_next;
    logic [63:0] msg;
    logic [2:0]  word_sel;
    sip_state_t  r;

    assign word_sel = step_reg[3:1];

    // message word for the current absorb
    always_comb
    begin
        case (word_sel)
            3'd0:    msg = w0;
            3'd1:    msg = w1;
            3'd2:    msg = w2;
            3'd3:    msg = w3;
            default: msg = {MSG_LEN, 24'd0, idx};
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        st_next   = st_reg;
        r         = st_reg;
        done      = 1'b0;
        if (start)
        begin
            st_next.v0 = SIP_IV0 ^ k0;
            st_next.v1 = SIP_IV1 ^ k1;
            st_next.v2 = SIP_IV2 ^ k0;
            st_next.v3 = SIP_IV3 ^ k1 ^ w0;
            step_next  = 4'd0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            r = sip_round(st_reg);
            st_next = r;
            step_next = step_reg + 4'd1;
            if (step_reg < 4'd10 && step_reg[0])
            begin
                // finish absorb, inject next word or finalization
                st_next.v0 = r.v0 ^ msg;
                if (step_reg == 4'd9)
                begin
                    st_next.v2 = r.v2 ^ 64'hff;
                end
                else
                begin
                    case (word_sel)
                        3'd0:    st_next.v3 = r.v3 ^ w1;
                        3'd1:    st_next.v3 = r.v3 ^ w2;
                        3'd2:    st_next.v3 = r.v3 ^ w3;
                        default: st_next.v3 = r.v3 ^ {MSG_LEN, 24'd0, idx};
                    endcase
                end
            end
            if (step_reg == 4'd13)
            begin
                run_next = 1'b0;
                done     = 1'b1;
            end
        end
    end

    assign hash = r.v0 ^ r.v1 ^ r.v2 ^ r.v3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end
endmodule

### sv/bfsip_mod.sv
// 64 by 21 bit remainder, restoring, one bit per cycle
module bfsip_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [20:0] den,
    output logic        done,
    output logic [20:0] rem
);
    logic [63:0] num_reg;
    logic [21:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic        run_reg;
    logic [21:0] trial;
    logic [21:0] sub;

    assign trial = {rem_reg[20:0], num_reg[63]};
    assign sub   = trial - {1'b0, den};
    assign done  = run_reg && (cnt_reg == 7'd64);
    assign rem   = rem_reg[20:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 7'd0;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
        end
    end

    // shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= 22'd0;
        end
        else if (run_reg && !done)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= sub[21] ? trial : sub;
        end
    end
endmodule

### sv/bloom_filter_siphash_insert_query.sv
// top level: siphash bloom filter with insert and query
// per hash: siphash, then remainder, then a memory read and a read-modify-write
// an item runs its hashes, then shows the result; one item at a time, busy high meanwhile
// after reset a clearing pass writes zero to all store bytes, one per cycle,
// with busy high; the configuration registers take their reset values
module bloom_filter_siphash_insert_query
    import bfsip_pkg::*;
#(
    parameter longint MAX_FILTER_BITS = 1048576
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  bfsip_in_t  in_item,
    output logic       result_valid,
    output bfsip_out_t result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    localparam longint STORE_BYTES = (MAX_FILTER_BITS + 7) / 8;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [AW-1:0] LAST_BYTE = AW'(STORE_BYTES - 1);
    localparam logic [20:0] MAX_SIZE = (MAX_FILTER_BITS > 2097151) ? 21'h1FFFFF
                                       : 21'(MAX_FILTER_BITS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_RMW   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [20:0] size_reg;
    logic [4:0]  count_reg;
    logic [63:0] seed_reg;
    bfsip_in_t   item_reg;
    logic [4:0]  hidx_reg, hidx_next;
    logic [4:0]  ncount_reg;
    logic [20:0] nsize_reg;
    logic [63:0] k0_reg, k1_reg, k0_next, k1_next;
    logic [63:0] m0_reg, m1_reg, m0_next, m1_next;
    logic        hit_reg, hit_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] byte_reg, byte_next;
    logic [2:0]  bit_reg, bit_next;

    logic        hash_start, hash_done;
    logic [63:0] hash_val;
    logic        mod_done;
    logic [20:0] mod_rem;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic        accept;
    logic [20:0] pos_byte;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= RESET_SIZE;
            count_reg <= RESET_COUNT;
            seed_reg  <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE:  size_reg  <= cfg_data[20:0];
                REG_COUNT: count_reg <= cfg_data[4:0];
                REG_SEED:  seed_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    bfsip_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .k0    (k0_reg),
        .k1    (k1_reg),
        .w0    (item_reg.txid_word0),
        .w1    (item_reg.txid_word1),
        .w2    (item_reg.txid_word2),
        .w3    (item_reg.txid_word3),
        .idx   (item_reg.out_index),
        .done  (hash_done),
        .hash  (hash_val)
    );

    bfsip_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_done),
        .num   (hash_val),
        .den   (nsize_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    bfsip_ram #(.WIDTH(8), .DEPTH(int'(STORE_BYTES))) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign pos_byte = {3'd0, mod_rem[20:3]};

    // control sequencer
    always_comb
    begin
        state_next = state_reg;
        hidx_next  = hidx_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        m0_next    = m0_reg;
        m1_next    = m1_reg;
        hit_next   = hit_reg;
        clr_next   = clr_reg;
        byte_next  = byte_reg;
        bit_next   = bit_reg;
        hash_start = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = byte_reg;
        ram_wdata  = ram_rdata | (8'd1 << bit_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 8'd0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_BYTE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    hidx_next  = 5'd0;
                    k0_next    = seed_reg;
                    k1_next    = seed_reg;
                    m0_next    = 64'd0;
                    m1_next    = 64'd0;
                    hit_next   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                hash_start = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    if (longint'(pos_byte) >= STORE_BYTES)
                    begin
                        byte_next = LAST_BYTE;
                    end
                    else
                    begin
                        byte_next = AW'(pos_byte);
                    end
                    bit_next   = mod_rem[2:0];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_RMW;
            end
            S_RMW:
            begin
                // next key pair by adding the constants once more
                m0_next   = m0_reg + KEY_MUL0;
                m1_next   = m1_reg + KEY_MUL1;
                k0_next   = seed_reg ^ m0_next;
                k1_next   = seed_reg ^ m1_next;
                hidx_next = hidx_reg + 5'd1;
                if (item_reg.mode)
                begin
                    if (!ram_rdata[bit_reg])
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                end
                if (hidx_reg + 5'd1 == ncount_reg)
                begin
                    state_next = S_DONE;
                end
                else if (!(item_reg.mode && !ram_rdata[bit_reg]))
                begin
                    state_next = S_HASH;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // item and per-hash working registers
    always_ff @(posedge clk)
    begin
        hidx_reg <= hidx_next;
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
        m0_reg   <= m0_next;
        m1_reg   <= m1_next;
        hit_reg  <= hit_next;
        byte_reg <= byte_next;
        bit_reg  <= bit_next;
        if (accept)
        begin
            item_reg <= in_item;
            if (count_reg == 5'd0)
                ncount_reg <= 5'd1;
            else if (count_reg > MAX_HASHES)
                ncount_reg <= MAX_HASHES;
            else
                ncount_reg <= count_reg;
            if (size_reg < MIN_SIZE)
                nsize_reg <= MIN_SIZE;
            else if (size_reg > MAX_SIZE)
                nsize_reg <= MAX_SIZE;
            else
                nsize_reg <= size_reg;
        end
    end

    // result beat
    assign result_valid       = (state_reg == S_DONE);
    assign result.was_query   = item_reg.mode;
    assign result.may_contain = item_reg.mode & hit_reg;
endmodule

### sv/bfsip_checker.sv
// port level checks for the bloom filter top level
module bfsip_checker
    import bfsip_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input bfsip_out_t result
);
    // accepted item raises busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // result only while busy, never two beats in a row
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("repeated result beat");

    // an insert never reports membership
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.was_query) |-> !result.may_contain)
        else $error("insert reported a hit");

    // after a result the block is free
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("busy after result");
endmodule

bind bloom_filter_siphash_insert_query bfsip_checker u_bfsip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### test/bloom_filter_siphash_insert_query_tb.sv
// testbench for the siphash bloom filter: directed and random inserts and queries against a predictor
module bloom_filter_siphash_insert_query_tb;
    import bfsip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint STORE_BITS = 1048576;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } lanes_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    bfsip_in_t   in_item = '0;
    logic        result_valid;
    bfsip_out_t  result;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_SIZE;
    logic [63:0] cfg_data = '0;

    bloom_filter_siphash_insert_query i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow of the filter and its registers
    bit          filter_bits [STORE_BITS];
    logic [20:0] size_reg = RESET_SIZE;
    logic [4:0]  count_reg = RESET_COUNT;
    logic [63:0] seed_reg = '0;

    bfsip_in_t   pending_items [$];
    bfsip_out_t  expected_results [$];
    bfsip_in_t   known_outpoints [$];
    int          idle_pct = 17;
    logic        took = 1'b0;
    int          errors = 0;
    longint      cycles = 0;
    int          n_inserts = 0;
    int          n_queries = 0;
    int          n_hits = 0;

    function automatic logic [63:0] rol(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic lanes_t sip_mix(input lanes_t s);
        s.v0 = s.v0 + s.v1; s.v1 = rol(s.v1, 13); s.v1 ^= s.v0; s.v0 = rol(s.v0, 32);
        s.v2 = s.v2 + s.v3; s.v3 = rol(s.v3, 16); s.v3 ^= s.v2;
        s.v0 = s.v0 + s.v3; s.v3 = rol(s.v3, 21); s.v3 ^= s.v0;
        s.v2 = s.v2 + s.v1; s.v1 = rol(s.v1, 17); s.v1 ^= s.v2; s.v2 = rol(s.v2, 32);
        return s;
    endfunction

    function automatic lanes_t sip_absorb(input lanes_t s, input logic [63:0] m);
        s.v3 ^= m;
        s = sip_mix(s);
        s = sip_mix(s);
        s.v0 ^= m;
        return s;
    endfunction

    // siphash-2-4 over the 36-byte outpoint
    function automatic logic [63:0] outpoint_hash(input logic [63:0] k0, input logic [63:0] k1,
                                                  input bfsip_in_t it);
        lanes_t s;
        s.v0 = SIP_IV0 ^ k0;
        s.v1 = SIP_IV1 ^ k1;
        s.v2 = SIP_IV2 ^ k0;
        s.v3 = SIP_IV3 ^ k1;
        s = sip_absorb(s, it.txid_word0);
        s = sip_absorb(s, it.txid_word1);
        s = sip_absorb(s, it.txid_word2);
        s = sip_absorb(s, it.txid_word3);
        s = sip_absorb(s, {MSG_LEN, 24'd0, it.out_index});
        s.v2 ^= 64'hFF;
        repeat (4) s = sip_mix(s);
        return s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
    endfunction

    // apply one beat to the shadow filter and give the result it should produce
    function automatic bfsip_out_t filter_apply(input bfsip_in_t it);
        bfsip_out_t  r;
        logic [63:0] modulus;
        logic [63:0] pos;
        logic [63:0] idx;
        int          nhash;
        logic        hit;
        modulus = 64'(size_reg);
        if (modulus < 64'(MIN_SIZE)) modulus = 64'(MIN_SIZE);
        if (modulus > 64'(STORE_BITS)) modulus = 64'(STORE_BITS);
        nhash = int'(count_reg);
        if (nhash < 1) nhash = 1;
        if (nhash > int'(MAX_HASHES)) nhash = int'(MAX_HASHES);
        hit = 1'b1;
        for (int i = 0; i < nhash; i++) begin
            idx = 64'(i);
            pos = outpoint_hash(seed_reg ^ (idx * KEY_MUL0), seed_reg ^ (idx * KEY_MUL1), it)
                  % modulus;
            if (!it.mode) begin
                filter_bits[pos] = 1'b1;
            end
            else if (!filter_bits[pos]) begin
                hit = 1'b0;
                break;
            end
        end
        r.was_query = it.mode;
        r.may_contain = it.mode & hit;
        return r;
    endfunction

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // accept beats and predict, check results
    always @(posedge clk)
    begin
        bfsip_out_t want;
        cycles <= cycles + 1;
        took <= start && !busy;
        if (start && !busy) begin
            expected_results.push_back(filter_apply(in_item));
            if (in_item.mode) n_queries++;
            else n_inserts++;
        end
        if (result_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: was_query=%0b may_contain=%0b",
                       result.was_query, result.may_contain);
                errors++;
            end
            else begin
                want = expected_results.pop_front();
                if (result.was_query !== want.was_query) begin
                    $error("was_query mismatch: expected %0b actual %0b",
                           want.was_query, result.was_query);
                    errors++;
                end
                if (result.may_contain !== want.may_contain) begin
                    $error("may_contain mismatch: expected %0b actual %0b",
                           want.may_contain, result.may_contain);
                    errors++;
                end
                if (want.may_contain) n_hits++;
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT) begin
            $display("bloom_filter_siphash_insert_query_tb NOT OK");
            $finish;
        end
    end

    // driver: hold a beat until taken, then maybe idle
    always @(negedge clk)
    begin
        logic nxt;
        nxt = start && !took;
        if (!nxt && rst_n && pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            in_item <= pending_items.pop_front();
            nxt = 1'b1;
        end
        start <= nxt;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_SIZE:  size_reg = value[20:0];
            REG_COUNT: count_reg = value[4:0];
            REG_SEED:  seed_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until the block has drained every beat
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() > 0 || start || expected_results.size() > 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bfsip_in_t rand_outpoint(input logic m);
        bfsip_in_t it;
        it.mode = m;
        it.txid_word0 = rand_word();
        it.txid_word1 = rand_word();
        it.txid_word2 = rand_word();
        it.txid_word3 = rand_word();
        it.out_index = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
        return it;
    endfunction

    // random mix: mostly insert-then-query of remembered outpoints
    task automatic queue_random(input int n);
        bfsip_in_t it;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    it = rand_outpoint(1'b0);
                    known_outpoints.push_back(it);
                    if (known_outpoints.size() > 64) void'(known_outpoints.pop_front());
                end
                4, 5, 6: begin
                    if (known_outpoints.size() > 0)
                        it = known_outpoints[$urandom_range(known_outpoints.size() - 1)];
                    else
                        it = rand_outpoint(1'b1);
                    it.mode = 1'b1;
                end
                7: begin
                    // near miss: same id, other output index
                    if (known_outpoints.size() > 0)
                        it = known_outpoints[$urandom_range(known_outpoints.size() - 1)];
                    else
                        it = rand_outpoint(1'b1);
                    it.mode = 1'b1;
                    it.out_index = it.out_index ^ (32'h1 << $urandom_range(31));
                end
                default: it = rand_outpoint(1'($urandom_range(1)));
            endcase
            pending_items.push_back(it);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        bfsip_in_t it;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // clearing pass runs first
        wait_drained();

        // directed at reset settings: extremes, insert then query
        idle_pct = 17;
        it = '0;
        pending_items.push_back(it);
        it.mode = 1'b1;
        pending_items.push_back(it);
        it = '1;
        it.mode = 1'b1;
        pending_items.push_back(it);
        it.mode = 1'b0;
        pending_items.push_back(it);
        it.mode = 1'b1;
        pending_items.push_back(it);
        for (int k = 0; k < 6; k++) begin
            it = rand_outpoint(1'b0);
            pending_items.push_back(it);
            it.mode = 1'b1;
            pending_items.push_back(it);
            it.txid_word2 = ~it.txid_word2;
            pending_items.push_back(it);
        end
        wait_drained();

        // size below range, count zero, random seed
        write_reg(REG_SIZE, 64'd0);
        write_reg(REG_COUNT, 64'd0);
        write_reg(REG_SEED, {$urandom, $urandom});
        queue_random(150);
        wait_drained();

        // size above range, count above range, seed all ones
        write_reg(REG_SIZE, 64'h1FFFFF);
        write_reg(REG_COUNT, 64'h1F);
        write_reg(REG_SEED, '1);
        idle_pct = 86;
        queue_random(30);
        wait_drained();

        // size changed later keeps old bits; size below the minimum
        write_reg(REG_SIZE, 64'd5);
        write_reg(REG_COUNT, 64'd2);
        queue_random(60);
        wait_drained();
        write_reg(REG_SIZE, 64'd1000);
        write_reg(REG_COUNT, 64'd3);
        write_reg(REG_SEED, {$urandom, $urandom});
        queue_random(340);
        wait_drained();

        // minimum size, single hash, zero seed, no idling
        idle_pct = 0;
        write_reg(REG_SIZE, 64'd8);
        write_reg(REG_COUNT, 64'd1);
        write_reg(REG_SEED, '0);
        queue_random(250);
        wait_drained();

        // unknown register index is ignored
        write_reg(2'd3, '1);
        write_reg(REG_SIZE, 64'd1048576);
        write_reg(REG_COUNT, 64'd2);
        write_reg(REG_SEED, {$urandom, $urandom});
        queue_random(575);
        wait_drained();
        repeat (20) @(negedge clk);

        $display("covered %0d inserts and %0d queries (%0d hits) over 7 register settings",
                 n_inserts, n_queries, n_hits);
        $display("sizes from below minimum to above maximum, 1 to 30 hashes, %0d cycles",
                 cycles);
        if (errors == 0)
            $display("bloom_filter_siphash_insert_query_tb OK");
        else
            $display("bloom_filter_siphash_insert_query_tb NOT OK");
        $finish;
    end

endmodule

### files.f
sv/bfsip_pkg.sv
sv/bfsip_ram.sv
sv/bfsip_hash.sv
sv/bfsip_mod.sv
sv/bloom_filter_siphash_insert_query.sv
sv/bfsip_checker.sv
test/bloom_filter_siphash_insert_query_tb.sv
